@@ src/nfcm_pkg.sv @@
package nfcm_pkg;

    localparam int unsigned ARRAY_WORDS_DEF = 131072;
    localparam int unsigned BLOCK_BYTES_DEF = 131072;
    localparam int unsigned CFI_LEN = 66;

    localparam logic [1:0] CHIP_IGNORE = 2'd0;
    localparam logic [1:0] CHIP_REJECT = 2'd1;
    localparam logic [1:0] CHIP_SINGLE = 2'd2;
    localparam logic [1:0] CHIP_DOUBLE = 2'd3;

    localparam logic [7:0] CMD_CFG     = 8'h03;
    localparam logic [7:0] CMD_LOCK    = 8'h01;
    localparam logic [7:0] CMD_UNLOCK  = 8'h2f;
    localparam logic [7:0] CMD_ERASE   = 8'h20;
    localparam logic [7:0] CMD_PROG    = 8'h40;
    localparam logic [7:0] CMD_CLRSTAT = 8'h50;
    localparam logic [7:0] CMD_SETUP60 = 8'h60;
    localparam logic [7:0] CMD_STATUS  = 8'h70;
    localparam logic [7:0] CMD_ID      = 8'h90;
    localparam logic [7:0] CMD_CFI     = 8'h98;
    localparam logic [7:0] CMD_STS     = 8'hb8;
    localparam logic [7:0] CMD_CONFIRM = 8'hd0;
    localparam logic [7:0] CMD_RESET   = 8'hff;

    localparam logic [12:0] BUSY_PROG  = 13'h0010;
    localparam logic [12:0] BUSY_ERASE = 13'h1000;

    typedef enum logic [2:0] {
        t_MODE_NORMAL = 3'd0,
        t_MODE_STATUS = 3'd1,
        t_MODE_SEEN60 = 3'd2,
        t_MODE_SETSTS = 3'd3,
        t_MODE_ID     = 3'd4,
        t_MODE_CFI    = 3'd5,
        t_MODE_ERASE1 = 3'd6,
        t_MODE_PROG1  = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_RD,
        t_ST_BURST,
        t_ST_PROG,
        t_ST_ERASE,
        t_ST_OUT,
        t_ST_CLEAR
    } t_state;

    function automatic logic [15:0] cfi_entry(input logic [6:0] i);
        logic [15:0] v;
        v = 16'h0;
        case (i)
            7'd0: v = 16'h51;  7'd1: v = 16'h52;  7'd2: v = 16'h59;  7'd3: v = 16'h1;
            7'd5: v = 16'h31;  7'd11: v = 16'h27; 7'd12: v = 16'h36;
            7'd15: v = 16'h8;  7'd16: v = 16'h9;  7'd17: v = 16'ha;
            7'd19: v = 16'h1;  7'd20: v = 16'h1;  7'd21: v = 16'h2;
            7'd23: v = 16'h18; 7'd24: v = 16'h1;  7'd26: v = 16'h6;
            7'd28: v = 16'h1;  7'd29: v = 16'h7f; 7'd32: v = 16'h3;
            7'd33: v = 16'h50; 7'd34: v = 16'h52; 7'd35: v = 16'h49;
            7'd36: v = 16'h31; 7'd37: v = 16'h31; 7'd38: v = 16'he6;
            7'd39: v = 16'h1;  7'd42: v = 16'h1;  7'd43: v = 16'h7;
            7'd45: v = 16'h33; 7'd47: v = 16'h2;  7'd48: v = 16'h80;
            7'd50: v = 16'h3;  7'd51: v = 16'h3;  7'd52: v = 16'h89;
            7'd59: v = 16'h10; 7'd61: v = 16'h4;  7'd62: v = 16'h4;
            7'd63: v = 16'h2;  7'd64: v = 16'h2;  7'd65: v = 16'h3;
            default: v = 16'h0;
        endcase
        return v;
    endfunction

endpackage

@@ src/nfcm_array.sv @@
module nfcm_array #(
    parameter int unsigned ARRAY_WORDS = nfcm_pkg::ARRAY_WORDS_DEF,
    localparam int unsigned AW = $clog2(ARRAY_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [ARRAY_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/nor_flash_command_machine_unit.sv @@
// NOR flash emulator with a CFI-style command set. One request enters on the input channel and
// the block then stalls until all its results are delivered. Command writes, command-mode
// reads and failed requests go from idle straight to the output state; an array read passes
// through the read state first; an N-word burst passes a burst and an output state per word; a
// program is a read-modify-write of one word, read while idle and written in the program
// state; a block erase writes one word per cycle over the block. After reset a clearing pass
// writes ones to every array word, during which no request is accepted.
module nor_flash_command_machine_unit #(
    parameter int unsigned ARRAY_WORDS = nfcm_pkg::ARRAY_WORDS_DEF,
    parameter int unsigned BLOCK_BYTES = nfcm_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [23:0] i_offset,
    input  logic [6:0]  i_size_bytes,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [31:0] o_read_data,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(ARRAY_WORDS);
    localparam logic [26:0] TOTAL = 27'(ARRAY_WORDS * 4);

    nfcm_pkg::t_state r_state, n_state;
    nfcm_pkg::t_mode r_mode, n_mode;
    logic [1:0]  r_chip, n_chip;
    logic [23:0] r_opaddr, n_opaddr;
    logic [15:0] r_rcfg, n_rcfg;
    logic [23:0] r_pend, n_pend;
    logic [12:0] r_busy, n_busy;
    logic [15:0] r_sts, n_sts;
    logic        r_op;
    logic [23:0] r_off;
    logic [6:0]  r_size;
    logic [31:0] r_wd;
    logic [AW:0] r_addr, n_addr;
    logic [AW:0] r_end, n_end;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_ok, n_ok;
    logic [31:0] r_data, n_data;
    logic        r_last, n_last;
    logic        r_erase_ok, n_erase_ok;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    nfcm_array #(.ARRAY_WORDS(ARRAY_WORDS)) u_array (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic        acc;
    logic        bad;
    logic        dbl;
    logic [23:0] idx;
    logic [15:0] cdata;
    logic        diff;
    logic [7:0]  cmd;
    logic        w_ok;
    logic        c_ok;
    logic [31:0] c_rep;
    logic        nodup;
    logic [26:0] blk_start, blk_end;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != nfcm_pkg::t_ST_IDLE);
    assign o_cfg_ready = (r_state == nfcm_pkg::t_ST_IDLE);

    always_comb begin
        logic [7:0] s;
        s = {1'b0, i_size_bytes};
        bad = (i_size_bytes == 7'd0) || ((i_size_bytes & (i_size_bytes - 7'd1)) != 7'd0)
            || ((i_offset & {17'd0, i_size_bytes - 7'd1}) != 24'd0)
            || ({3'd0, i_offset} + {19'd0, s} > TOTAL);
        dbl = (r_chip == nfcm_pkg::CHIP_DOUBLE);
        idx = dbl ? {2'd0, i_offset[23:2]} : {1'b0, i_offset[23:1]};
        cdata = i_write_data[15:0];
        diff = dbl && (i_write_data[15:0] != i_write_data[31:16]);
        cmd = cdata[7:0];
        if (dbl) begin
            blk_start = {3'd0, i_offset} & ~(27'(2 * BLOCK_BYTES) - 27'd1);
            blk_end = blk_start + 27'(2 * BLOCK_BYTES);
        end else begin
            blk_start = {3'd0, i_offset} & ~(27'(BLOCK_BYTES) - 27'd1);
            blk_end = blk_start + 27'(BLOCK_BYTES);
        end
    end

    always_comb begin
        logic [15:0] r16;
        r16 = 16'd0;
        nodup = 1'b0;
        c_ok = 1'b1;
        if (r_chip == nfcm_pkg::CHIP_SINGLE) begin
            c_ok = (i_size_bytes == 7'd2);
        end else if (dbl) begin
            c_ok = (i_size_bytes == 7'd4);
        end else begin
            c_ok = 1'b0;
        end
        c_rep = 32'd0;
        if (r_mode == nfcm_pkg::t_MODE_STATUS) begin
            r16 = (r_busy != 13'd0) ? 16'h0 : 16'h0080;
        end else if (r_mode == nfcm_pkg::t_MODE_ID) begin
            if (idx == 24'd0) r16 = 16'h0089;
            else if (idx == 24'd1) r16 = 16'h8802;
            else if (idx == 24'd5) r16 = r_rcfg;
            else if (idx == 24'h80) r16 = 16'h2;
            else if (idx == 24'h81) begin c_rep = 32'h001d0017; nodup = 1'b1; end
            else if (idx == 24'h82) begin c_rep = 32'h000a0003; nodup = 1'b1; end
            else if (idx == 24'h83) begin c_rep = 32'h3fb03fa6; nodup = 1'b1; end
            else if (idx == 24'h84) begin c_rep = 32'h48d9c99a; nodup = 1'b1; end
            else if (idx >= 24'h85 && idx <= 24'h88) r16 = 16'hffff;
            else if (idx >= 24'h89 && idx <= 24'h109) r16 = 16'h0;
            else if (idx[14:0] == 15'd0) r16 = 16'h89;
            else if (idx[14:0] == 15'd2) r16 = 16'h0;
            else r16 = 16'hffff;
        end else begin
            if (idx == 24'd0) r16 = 16'h0089;
            else if (idx == 24'd1) r16 = 16'h8802;
            else if (idx >= 24'h10 && idx < 24'(16 + nfcm_pkg::CFI_LEN))
                r16 = nfcm_pkg::cfi_entry(7'(idx - 24'h10));
            else if (idx[15:0] == 16'd2) r16 = 16'h0;
            else c_ok = 1'b0;
        end
        if (!nodup) c_rep = {r16, r16};
        if (r_chip == nfcm_pkg::CHIP_SINGLE) c_rep = {16'd0, c_rep[15:0]};
        if (!c_ok) c_rep = 32'd0;
    end

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        n_chip = r_chip;
        n_opaddr = r_opaddr;
        n_rcfg = r_rcfg;
        n_pend = r_pend;
        n_busy = r_busy;
        n_sts = r_sts;
        n_addr = r_addr;
        n_end = r_end;
        n_cnt = r_cnt;
        n_ok = r_ok;
        n_data = r_data;
        n_last = r_last;
        n_erase_ok = r_erase_ok;
        w_ok = 1'b1;
        if (i_cfg_valid && o_cfg_ready) n_chip = i_cfg_data;
        case (r_state)
            nfcm_pkg::t_ST_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == (AW+1)'(ARRAY_WORDS - 1)) n_state = nfcm_pkg::t_ST_IDLE;
            end
            nfcm_pkg::t_ST_IDLE: begin
                if (acc) begin
                    n_ok = 1'b0;
                    n_data = 32'd0;
                    n_last = 1'b1;
                    n_state = nfcm_pkg::t_ST_OUT;
                    n_addr = {1'b0, i_offset[AW+1:2]};
                    if (bad) begin
                        n_ok = 1'b0;
                    end else if (i_op) begin
                        if (r_chip == nfcm_pkg::CHIP_IGNORE) w_ok = 1'b1;
                        else if (r_chip == nfcm_pkg::CHIP_REJECT) w_ok = 1'b0;
                        else if (dbl && i_size_bytes != 7'd4) w_ok = 1'b0;
                        else if (!dbl && i_size_bytes != 7'd2) w_ok = 1'b0;
                        else if (r_mode == nfcm_pkg::t_MODE_SETSTS) begin
                            if (diff) w_ok = 1'b0;
                            else begin n_sts = cdata; n_mode = nfcm_pkg::t_MODE_NORMAL; end
                        end else if (r_mode == nfcm_pkg::t_MODE_SEEN60) begin
                            if (diff) w_ok = 1'b0;
                            else if (cdata == 16'(nfcm_pkg::CMD_CFG)) begin
                                if (r_pend != idx) w_ok = 1'b0;
                                else begin
                                    n_rcfg = idx[15:0];
                                    n_mode = nfcm_pkg::t_MODE_NORMAL;
                                end
                            end else if (cdata == 16'(nfcm_pkg::CMD_LOCK)
                                || cdata == 16'(nfcm_pkg::CMD_CONFIRM)
                                || cdata == 16'(nfcm_pkg::CMD_UNLOCK)) begin
                                n_mode = nfcm_pkg::t_MODE_NORMAL;
                            end else w_ok = 1'b0;
                        end else if (r_mode == nfcm_pkg::t_MODE_PROG1) begin
                            if (i_offset != r_opaddr) w_ok = 1'b0;
                            else begin
                                n_busy = nfcm_pkg::BUSY_PROG;
                                n_mode = nfcm_pkg::t_MODE_STATUS;
                                n_state = nfcm_pkg::t_ST_PROG;
                            end
                        end else if (diff) w_ok = 1'b1;
                        else if (cmd == nfcm_pkg::CMD_STS) n_mode = nfcm_pkg::t_MODE_SETSTS;
                        else if (cmd == nfcm_pkg::CMD_ERASE || cmd == nfcm_pkg::CMD_PROG) begin
                            if (r_mode != nfcm_pkg::t_MODE_NORMAL) w_ok = 1'b0;
                            else begin
                                n_mode = (cmd == nfcm_pkg::CMD_ERASE)
                                    ? nfcm_pkg::t_MODE_ERASE1 : nfcm_pkg::t_MODE_PROG1;
                                n_opaddr = i_offset;
                            end
                        end else if (cmd == nfcm_pkg::CMD_CONFIRM) begin
                            if (r_mode != nfcm_pkg::t_MODE_ERASE1 || i_offset != r_opaddr)
                                w_ok = 1'b0;
                            else begin
                                n_addr = blk_start[AW+2:2];
                                n_erase_ok = (blk_end <= TOTAL);
                                n_end = (blk_end <= TOTAL) ? blk_end[AW+2:2]
                                    : (AW+1)'(ARRAY_WORDS);
                                n_state = nfcm_pkg::t_ST_ERASE;
                                if (blk_end <= TOTAL) begin
                                    n_busy = nfcm_pkg::BUSY_ERASE;
                                    n_mode = nfcm_pkg::t_MODE_STATUS;
                                end
                            end
                        end else if (cmd != nfcm_pkg::CMD_CLRSTAT && cmd != nfcm_pkg::CMD_SETUP60
                            && cmd != nfcm_pkg::CMD_STATUS && cmd != nfcm_pkg::CMD_ID
                            && cmd != nfcm_pkg::CMD_CFI && cmd != nfcm_pkg::CMD_RESET)
                            w_ok = 1'b0;
                        else if (r_mode == nfcm_pkg::t_MODE_ERASE1) w_ok = 1'b0;
                        else if (cmd == nfcm_pkg::CMD_SETUP60) begin
                            n_pend = idx;
                            n_mode = nfcm_pkg::t_MODE_SEEN60;
                        end else if (cmd == nfcm_pkg::CMD_STATUS) n_mode = nfcm_pkg::t_MODE_STATUS;
                        else if (cmd == nfcm_pkg::CMD_ID) n_mode = nfcm_pkg::t_MODE_ID;
                        else if (cmd == nfcm_pkg::CMD_CFI) n_mode = nfcm_pkg::t_MODE_CFI;
                        else n_mode = nfcm_pkg::t_MODE_NORMAL;
                        n_ok = w_ok;
                    end else if (r_mode == nfcm_pkg::t_MODE_STATUS || r_mode == nfcm_pkg::t_MODE_ID
                        || r_mode == nfcm_pkg::t_MODE_CFI) begin
                        n_ok = c_ok;
                        n_data = c_rep;
                        if (c_ok && r_mode == nfcm_pkg::t_MODE_STATUS) begin
                            if (r_busy != 13'd0) n_busy = r_busy - 13'd1;
                            else n_mode = nfcm_pkg::t_MODE_NORMAL;
                        end
                    end else if (r_mode == nfcm_pkg::t_MODE_NORMAL
                        || r_mode == nfcm_pkg::t_MODE_SEEN60) begin
                        n_cnt = 5'(i_size_bytes[6:2]);
                        n_state = (i_size_bytes >= 7'd4) ? nfcm_pkg::t_ST_BURST
                            : nfcm_pkg::t_ST_RD;
                    end
                end
            end
            nfcm_pkg::t_ST_RD: begin
                n_ok = 1'b1;
                n_last = 1'b1;
                if (r_size == 7'd1) n_data = {24'd0, 8'(mem_rdata >> {r_off[1:0], 3'd0})};
                else n_data = {16'd0, r_off[1] ? mem_rdata[31:16] : mem_rdata[15:0]};
                n_state = nfcm_pkg::t_ST_OUT;
            end
            nfcm_pkg::t_ST_BURST: begin
                n_ok = 1'b1;
                n_data = mem_rdata;
                n_last = (r_cnt == 5'd1);
                n_state = nfcm_pkg::t_ST_OUT;
            end
            nfcm_pkg::t_ST_PROG: begin
                n_ok = 1'b1;
                n_state = nfcm_pkg::t_ST_OUT;
            end
            nfcm_pkg::t_ST_ERASE: begin
                n_addr = r_addr + 1'b1;
                if (r_addr + 1'b1 >= r_end) begin
                    n_ok = r_erase_ok;
                    n_state = nfcm_pkg::t_ST_OUT;
                end
            end
            nfcm_pkg::t_ST_OUT: begin
                if (!i_stall) begin
                    if (!r_last) begin
                        n_cnt = r_cnt - 5'd1;
                        n_addr = r_addr + 1'b1;
                        n_state = nfcm_pkg::t_ST_BURST;
                    end else n_state = nfcm_pkg::t_ST_IDLE;
                end
            end
            default: n_state = nfcm_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        mem_raddr = r_addr[AW-1:0];
        mem_we = 1'b0;
        mem_waddr = r_addr[AW-1:0];
        mem_wdata = 32'hffffffff;
        if (r_state == nfcm_pkg::t_ST_IDLE) begin
            mem_raddr = i_offset[AW+1:2];
        end
        case (r_state)
            nfcm_pkg::t_ST_CLEAR: mem_we = 1'b1;
            nfcm_pkg::t_ST_ERASE: mem_we = 1'b1;
            nfcm_pkg::t_ST_OUT: mem_raddr = AW'(r_addr + 1'b1);
            nfcm_pkg::t_ST_PROG: begin
                mem_we = 1'b1;
                if (r_chip == nfcm_pkg::CHIP_DOUBLE) mem_wdata = mem_rdata & r_wd;
                else if (r_off[1]) mem_wdata = mem_rdata & {r_wd[15:0], 16'hffff};
                else mem_wdata = mem_rdata & {16'hffff, r_wd[15:0]};
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfcm_pkg::t_ST_CLEAR;
            r_mode <= nfcm_pkg::t_MODE_NORMAL;
            r_chip <= nfcm_pkg::CHIP_SINGLE;
            r_opaddr <= 24'd0;
            r_rcfg <= 16'hc0c2;
            r_pend <= 24'd0;
            r_busy <= 13'd0;
            r_sts <= 16'd0;
            r_addr <= '0;
        end else begin
            r_state <= n_state;
            r_mode <= n_mode;
            r_chip <= n_chip;
            r_opaddr <= n_opaddr;
            r_rcfg <= n_rcfg;
            r_pend <= n_pend;
            r_busy <= n_busy;
            r_sts <= n_sts;
            r_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op <= i_op;
            r_off <= i_offset;
            r_size <= i_size_bytes;
            r_wd <= i_write_data;
        end
        r_end <= n_end;
        r_cnt <= n_cnt;
        r_ok <= n_ok;
        r_data <= n_data;
        r_last <= n_last;
        r_erase_ok <= n_erase_ok;
    end

    assign o_valid = (r_state == nfcm_pkg::t_ST_OUT);
    assign o_ok = r_ok;
    assign o_read_data = r_data;
    assign o_last = r_last;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nfcm_pkg::t_ST_IDLE) |-> !acc) else $error("request taken while busy");
    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_op && r_state == nfcm_pkg::t_ST_OUT) |-> (r_last && r_data == 32'd0))
        else $error("write gave burst or data");
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && bad) |=> o_valid && !o_ok) else $error("bad request not failed at once");
    a_sts_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfcm_pkg::t_ST_PROG) |-> (r_mode == nfcm_pkg::t_MODE_STATUS))
        else $error("program without status mode");
    a_sts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_sts)) else $error("sts changed without request");

endmodule
